// ===== hw/rtl/owtr_pkg.sv =====
// shared types, register indexes and constants for the one-wire temperature reader
package owtr_pkg;

  localparam int unsigned TickW   = 18;
  localparam int unsigned TimeW   = 8;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 18;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] RegResetLow   = 3'd0;
  localparam logic [CfgAddrW-1:0] RegResetWait  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegWriteSlot  = 3'd2;
  localparam logic [CfgAddrW-1:0] RegRecovery   = 3'd3;
  localparam logic [CfgAddrW-1:0] RegReadWait   = 3'd4;
  localparam logic [CfgAddrW-1:0] RegConvWait   = 3'd5;

  // reset values of the timing registers
  localparam logic [TimeW-1:0] ResetLowInit  = 8'd120;
  localparam logic [TimeW-1:0] ResetWaitInit = 8'd96;
  localparam logic [TimeW-1:0] WriteSlotInit = 8'd12;
  localparam logic [TimeW-1:0] RecoveryInit  = 8'd5;
  localparam logic [TimeW-1:0] ReadWaitInit  = 8'd11;
  localparam logic [TickW-1:0] ConvWaitInit  = 18'd0;

  // bus commands
  localparam logic [7:0] CmdSkipRom  = 8'hCC;
  localparam logic [7:0] CmdConvert  = 8'h44;
  localparam logic [7:0] CmdReadPad  = 8'hBE;

  // sequence steps
  localparam logic [3:0] OpReset1   = 4'd0;
  localparam logic [3:0] OpSkip1    = 4'd1;
  localparam logic [3:0] OpConvert  = 4'd2;
  localparam logic [3:0] OpConvWait = 4'd3;
  localparam logic [3:0] OpReset2   = 4'd4;
  localparam logic [3:0] OpSkip2    = 4'd5;
  localparam logic [3:0] OpReadCmd  = 4'd6;
  localparam logic [3:0] OpReadLo   = 4'd7;
  localparam logic [3:0] OpReadHi   = 4'd8;

  typedef struct packed {
    logic [TimeW-1:0] reset_low;
    logic [TimeW-1:0] reset_wait;
    logic [TimeW-1:0] write_slot;
    logic [TimeW-1:0] recovery;
    logic [TimeW-1:0] read_wait;
    logic [TickW-1:0] conv_wait;
  } owtr_cfg_t;

  typedef struct packed {
    logic        pull_low;
    logic        busy;
    logic        done;
    logic [15:0] raw;
  } owtr_res_t;

  function automatic logic [7:0] cmd_of_step(input logic [3:0] op);
    logic [7:0] c;
    case (op)
      OpSkip1:   c = CmdSkipRom;
      OpConvert: c = CmdConvert;
      OpSkip2:   c = CmdSkipRom;
      OpReadCmd: c = CmdReadPad;
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

  // zero timing values count as one tick
  function automatic logic [TimeW-1:0] at_least_one(input logic [TimeW-1:0] v);
    return (v == '0) ? TimeW'(1) : v;
  endfunction

endpackage

// ===== hw/rtl/owtr_cfg.sv =====
// timing configuration registers
module owtr_cfg
  import owtr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output owtr_cfg_t           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low  <= ResetLowInit;
      cfg.reset_wait <= ResetWaitInit;
      cfg.write_slot <= WriteSlotInit;
      cfg.recovery   <= RecoveryInit;
      cfg.read_wait  <= ReadWaitInit;
      cfg.conv_wait  <= ConvWaitInit;
    end else if (cfg_write) begin
      case (cfg_addr)
        RegResetLow:  cfg.reset_low  <= cfg_wdata[TimeW-1:0];
        RegResetWait: cfg.reset_wait <= cfg_wdata[TimeW-1:0];
        RegWriteSlot: cfg.write_slot <= cfg_wdata[TimeW-1:0];
        RegRecovery:  cfg.recovery   <= cfg_wdata[TimeW-1:0];
        RegReadWait:  cfg.read_wait  <= cfg_wdata[TimeW-1:0];
        RegConvWait:  cfg.conv_wait  <= cfg_wdata[TickW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/owtr_core.sv =====
// bus sequencer: state registers and per-tick next-state logic
module owtr_core
  import owtr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic      start_req,
  input  logic      bus_level,
  input  owtr_cfg_t cfg,
  output owtr_res_t res
);

  logic [3:0]       op_index,   op_index_next;
  logic [1:0]       slot_phase, slot_phase_next;
  logic [TickW-1:0] tick_count, tick_count_next;
  logic [2:0]       bit_count,  bit_count_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [7:0]       low_byte,   low_byte_next;
  logic [15:0]      last_raw,   last_raw_next;
  logic             running,    running_next;

  logic [TickW:0]   tick_inc;
  logic [TickW-1:0] target;
  logic             done;
  logic [3:0]       op_adv;
  logic [7:0]       cmd_byte;
  logic             cmd_bit;

  always_comb begin
    running_next    = running;
    op_index_next   = op_index;
    slot_phase_next = slot_phase;
    tick_count_next = tick_count;
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    low_byte_next   = low_byte;
    last_raw_next   = last_raw;
    res.pull_low    = 1'b0;
    res.busy        = 1'b0;
    res.done        = 1'b0;

    if (!running && start_req) begin
      running_next    = 1'b1;
      op_index_next   = OpReset1;
      slot_phase_next = 2'd0;
      tick_count_next = '0;
      bit_count_next  = '0;
      shift_byte_next = '0;
    end

    // phase timer target for the current step and phase
    case (op_index_next)
      OpReset1, OpReset2:
        target = (slot_phase_next == 2'd0) ? TickW'(at_least_one(cfg.reset_low))
                                           : TickW'(at_least_one(cfg.reset_wait));
      OpSkip1, OpConvert, OpSkip2, OpReadCmd:
        target = (slot_phase_next == 2'd1) ? TickW'(at_least_one(cfg.write_slot))
                                           : TickW'(at_least_one(cfg.recovery));
      OpConvWait: target = cfg.conv_wait;
      default:    target = TickW'(at_least_one(cfg.read_wait));
    endcase
    tick_inc = {1'b0, tick_count_next} + 1'b1;
    done     = tick_inc >= {1'b0, target};
    cmd_byte = cmd_of_step(op_index_next);
    cmd_bit  = cmd_byte[bit_count_next];
    // next step, with the conversion wait skipped when it is zero
    op_adv   = (op_index_next == OpConvert && cfg.conv_wait == '0) ? OpReset2
                                                                     : op_index_next + 4'd1;

    if (running_next) begin
      res.busy = 1'b1;
      case (op_index_next)
        OpReset1, OpReset2: begin
          res.pull_low    = (slot_phase_next == 2'd0);
          tick_count_next = done ? '0 : tick_inc[TickW-1:0];
          if (done) begin
            if (slot_phase_next == 2'd0) begin
              slot_phase_next = 2'd1;
            end else begin
              op_index_next   = op_adv;
              slot_phase_next = 2'd0;
              bit_count_next  = '0;
            end
          end
        end
        OpSkip1, OpConvert, OpSkip2, OpReadCmd: begin
          if (slot_phase_next == 2'd0) begin
            res.pull_low    = 1'b1;
            slot_phase_next = 2'd1;
            tick_count_next = '0;
          end else if (slot_phase_next == 2'd1) begin
            res.pull_low    = ~cmd_bit;
            tick_count_next = done ? '0 : tick_inc[TickW-1:0];
            if (done) slot_phase_next = 2'd2;
          end else begin
            tick_count_next = done ? '0 : tick_inc[TickW-1:0];
            if (done) begin
              slot_phase_next = 2'd0;
              if (bit_count_next == 3'd7) begin
                op_index_next  = op_adv;
                bit_count_next = '0;
              end else begin
                bit_count_next = bit_count_next + 3'd1;
              end
            end
          end
        end
        OpConvWait: begin
          tick_count_next = done ? '0 : tick_inc[TickW-1:0];
          if (done) begin
            op_index_next   = op_adv;
            slot_phase_next = 2'd0;
            bit_count_next  = '0;
          end
        end
        OpReadLo, OpReadHi: begin
          if (slot_phase_next == 2'd0) begin
            res.pull_low    = 1'b1;
            slot_phase_next = 2'd1;
            tick_count_next = '0;
          end else if (slot_phase_next == 2'd1) begin
            shift_byte_next = {bus_level, shift_byte_next[7:1]};
            slot_phase_next = 2'd2;
            tick_count_next = '0;
          end else begin
            tick_count_next = done ? '0 : tick_inc[TickW-1:0];
            if (done) begin
              slot_phase_next = 2'd0;
              if (bit_count_next != 3'd7) begin
                bit_count_next = bit_count_next + 3'd1;
              end else if (op_index_next == OpReadLo) begin
                low_byte_next  = shift_byte_next;
                op_index_next  = op_adv;
                bit_count_next = '0;
              end else begin
                last_raw_next  = {shift_byte_next, low_byte_next};
                res.done       = 1'b1;
                running_next   = 1'b0;
                op_index_next  = OpReset1;
                bit_count_next = '0;
                tick_count_next = '0;
              end
            end
          end
        end
        default: begin
          running_next    = 1'b0;
          op_index_next   = OpReset1;
          slot_phase_next = 2'd0;
          tick_count_next = '0;
          bit_count_next  = '0;
        end
      endcase
    end
    res.raw = last_raw_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      op_index   <= '0;
      slot_phase <= '0;
      tick_count <= '0;
      bit_count  <= '0;
      shift_byte <= '0;
      low_byte   <= '0;
      last_raw   <= '0;
    end else if (step) begin
      running    <= running_next;
      op_index   <= op_index_next;
      slot_phase <= slot_phase_next;
      tick_count <= tick_count_next;
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
      low_byte   <= low_byte_next;
      last_raw   <= last_raw_next;
    end
  end

endmodule

// ===== hw/rtl/owtr_disp.sv =====
// temperature and decimal display digits from the raw reading
module owtr_disp
  import owtr_pkg::*;
(
  input  logic [15:0] raw,
  output logic [7:0]  temp,
  output logic [3:0]  tens,
  output logic [3:0]  ones
);

  logic [15:0] prod;
  logic [4:0]  quot;
  logic [7:0]  quot_x10;

  // divide by ten: x*205 >> 11 is exact for all eight-bit x
  assign temp     = raw[11:4];
  assign prod     = 16'(temp) * 16'd205;
  assign quot     = prod[15:11];
  assign quot_x10 = ({3'b000, quot} << 3) + ({3'b000, quot} << 1);
  assign tens     = quot[3:0];
  assign ones     = 4'(temp - quot_x10);

endmodule

// ===== hw/rtl/onewire_temp_reader.sv =====
// top level of the one-wire temperature reader
//
// one beat on the input channel is one bus time tick: start_req asks for a
// new reading while idle, bus_level is the sampled line. every input beat
// gives exactly one output beat carrying the bus drive (pull_low), busy_res,
// reading_valid on the tick the last read slot ends, and the latched raw
// reading with its temperature (raw bits 11:4) and tens/ones display digits.
// the accept edge loads the input register; once the result slot is free,
// the tick moves through the sequencer step logic into the result
// register. throughput is one beat per cycle while out_ready stays high;
// the sequencer state updates once per tick so the next may follow.
// if out_ready is low the result register holds, the input register still
// takes one more beat, then in_ready drops until the result is taken.
// reset clears the sequencer to idle, the latched reading to zero, both
// pipeline registers to empty and the timing registers to their defaults.
// timing registers are written through cfg_write/cfg_addr/cfg_wdata and
// should only change while no beat is in flight.
module onewire_temp_reader
  import owtr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_write,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  // tick input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                start_req,
  input  logic                bus_level,
  // result output
  output logic                out_valid,
  input  logic                out_ready,
  output logic                pull_low,
  output logic                busy_res,
  output logic                reading_valid,
  output logic [15:0]         raw_reading,
  output logic [7:0]          temperature,
  output logic [3:0]          tens_digit,
  output logic [3:0]          ones_digit
);

  owtr_cfg_t cfg;
  owtr_res_t res;

  // input register
  logic in_full;
  logic start_q;
  logic level_q;

  logic advance;
  logic [7:0] temp_c;
  logic [3:0] tens_c;
  logic [3:0] ones_c;

  // a tick moves into the result register when the result slot is free
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  owtr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  owtr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .start_req (start_q),
    .bus_level (level_q),
    .cfg       (cfg),
    .res       (res)
  );

  owtr_disp u_disp (
    .raw  (res.raw),
    .temp (temp_c),
    .tens (tens_c),
    .ones (ones_c)
  );

  // input beat capture
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      start_q <= start_req;
      level_q <= bus_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      pull_low      <= res.pull_low;
      busy_res      <= res.busy;
      reading_valid <= res.done;
      raw_reading   <= res.raw;
      temperature   <= temp_c;
      tens_digit    <= tens_c;
      ones_digit    <= ones_c;
    end
  end

endmodule

// ===== bench/owtr_result_check.sv =====
// tick predictor and result comparison for the one-wire temperature reader bench
module owtr_result_check
  import owtr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                start_req,
  input  logic                bus_level,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                pull_low,
  input  logic                busy_res,
  input  logic                reading_valid,
  input  logic [15:0]         raw_reading,
  input  logic [7:0]          temperature,
  input  logic [3:0]          tens_digit,
  input  logic [3:0]          ones_digit,
  output int unsigned         err_total,
  output int unsigned         left_over,
  output logic                seq_busy
);

  // slot phases within one sequence step
  localparam logic [1:0] PhFirst  = 2'd0;
  localparam logic [1:0] PhSecond = 2'd1;
  localparam logic [1:0] PhThird  = 2'd2;

  localparam int unsigned TickMask   = (1 << TickW) - 1;

  typedef struct packed {
    logic        pull_low;
    logic        busy;
    logic        done;
    logic [15:0] raw;
    logic [7:0]  temp;
    logic [3:0]  tens;
    logic [3:0]  ones;
  } tick_view_t;

  owtr_cfg_t   timing;
  logic [3:0]  seq_step;
  logic [1:0]  slot_ph;
  int unsigned tick_cnt;
  logic [2:0]  bit_idx;
  logic [7:0]  rx_byte;
  logic [7:0]  lo_byte;
  logic [15:0] latched;
  logic        active;

  tick_view_t  expected_ticks[$];
  int unsigned errors = 0;
  int unsigned pending_q = 0;
  logic        busy_q = 1'b0;

  assign err_total = errors;
  assign left_over = pending_q;
  assign seq_busy  = busy_q;

  function automatic int unsigned min_one(input logic [TimeW-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  // counts one tick of a timed phase, true on its last tick
  function automatic bit phase_over(input int unsigned target);
    if (tick_cnt + 1 >= target) begin
      tick_cnt = 0;
      return 1'b1;
    end
    tick_cnt = (tick_cnt + 1) & TickMask;
    return 1'b0;
  endfunction

  function automatic void go_idle();
    active   = 1'b0;
    seq_step = OpReset1;
    slot_ph  = PhFirst;
    tick_cnt = 0;
    bit_idx  = '0;
  endfunction

  function automatic void advance_step();
    seq_step = seq_step + 4'd1;
    slot_ph  = PhFirst;
    tick_cnt = 0;
    bit_idx  = '0;
    if (seq_step == OpConvWait && timing.conv_wait == '0) seq_step = OpReset2;
  endfunction

  function automatic tick_view_t predict_tick(input logic start, input logic level);
    tick_view_t r;
    logic [7:0] cmd;
    logic       drive;
    logic       done_now;
    logic       busy_now;
    drive    = 1'b0;
    done_now = 1'b0;
    if (!active && start) begin
      active   = 1'b1;
      seq_step = OpReset1;
      slot_ph  = PhFirst;
      tick_cnt = 0;
      bit_idx  = '0;
      rx_byte  = '0;
    end
    // busy covers every tick of a sequence, including the one that ends it
    busy_now = active;
    if (active) begin
      case (seq_step)
        OpReset1, OpReset2: begin
          if (slot_ph == PhFirst) begin
            drive = 1'b1;
            if (phase_over(min_one(timing.reset_low))) slot_ph = PhSecond;
          end else if (phase_over(min_one(timing.reset_wait))) begin
            advance_step();
          end
        end
        OpSkip1, OpConvert, OpSkip2, OpReadCmd: begin
          cmd = (seq_step == OpConvert) ? CmdConvert :
                (seq_step == OpReadCmd) ? CmdReadPad : CmdSkipRom;
          if (slot_ph == PhFirst) begin
            drive    = 1'b1;
            slot_ph  = PhSecond;
            tick_cnt = 0;
          end else if (slot_ph == PhSecond) begin
            drive = ~cmd[bit_idx];
            if (phase_over(min_one(timing.write_slot))) slot_ph = PhThird;
          end else if (phase_over(min_one(timing.recovery))) begin
            if (bit_idx == 3'd7) begin
              advance_step();
            end else begin
              bit_idx = bit_idx + 3'd1;
              slot_ph = PhFirst;
            end
          end
        end
        OpConvWait: begin
          if (phase_over(int'(timing.conv_wait))) advance_step();
        end
        OpReadLo, OpReadHi: begin
          if (slot_ph == PhFirst) begin
            drive    = 1'b1;
            slot_ph  = PhSecond;
            tick_cnt = 0;
          end else if (slot_ph == PhSecond) begin
            rx_byte  = {level, rx_byte[7:1]};
            slot_ph  = PhThird;
            tick_cnt = 0;
          end else if (phase_over(min_one(timing.read_wait))) begin
            if (bit_idx != 3'd7) begin
              bit_idx = bit_idx + 3'd1;
              slot_ph = PhFirst;
            end else if (seq_step == OpReadLo) begin
              lo_byte = rx_byte;
              advance_step();
            end else begin
              latched  = {rx_byte, lo_byte};
              done_now = 1'b1;
              go_idle();
            end
          end
        end
        default: go_idle();
      endcase
    end
    r.pull_low = drive;
    r.busy     = busy_now;
    r.done     = done_now;
    r.raw      = latched;
    r.temp     = latched[11:4];
    r.tens     = 4'(r.temp / 8'd10);
    r.ones     = 4'(r.temp % 8'd10);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    tick_view_t want;
    if (rst) begin
      timing.reset_low  = ResetLowInit;
      timing.reset_wait = ResetWaitInit;
      timing.write_slot = WriteSlotInit;
      timing.recovery   = RecoveryInit;
      timing.read_wait  = ReadWaitInit;
      timing.conv_wait  = ConvWaitInit;
      go_idle();
      rx_byte = '0;
      lo_byte = '0;
      latched = '0;
      expected_ticks.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_addr)
          RegResetLow:  timing.reset_low  = cfg_wdata[TimeW-1:0];
          RegResetWait: timing.reset_wait = cfg_wdata[TimeW-1:0];
          RegWriteSlot: timing.write_slot = cfg_wdata[TimeW-1:0];
          RegRecovery:  timing.recovery   = cfg_wdata[TimeW-1:0];
          RegReadWait:  timing.read_wait  = cfg_wdata[TimeW-1:0];
          RegConvWait:  timing.conv_wait  = cfg_wdata[TickW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_ticks.push_back(predict_tick(start_req, bus_level));
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual raw %0h",
                   $time, raw_reading);
          errors++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("pull_low", 16'(want.pull_low), 16'(pull_low));
          check_field("busy_res", 16'(want.busy), 16'(busy_res));
          check_field("reading_valid", 16'(want.done), 16'(reading_valid));
          check_field("raw_reading", want.raw, raw_reading);
          check_field("temperature", 16'(want.temp), 16'(temperature));
          check_field("tens_digit", 16'(want.tens), 16'(tens_digit));
          check_field("ones_digit", 16'(want.ones), 16'(ones_digit));
        end
      end
    end
    pending_q <= expected_ticks.size();
    busy_q    <= active;
  end

endmodule

// ===== bench/testbench.sv =====
// top of the one-wire temperature reader bench: clock, reset, stimulus and verdict
module testbench;
  import owtr_pkg::*;

  // bus level patterns for a stretch of ticks
  localparam int LvlLow   = 0;
  localparam int LvlHigh  = 1;
  localparam int LvlNoise = 2;

  // receiver ready patterns, picked anew at random by the receiver side
  localparam int unsigned RxAlways     = 0;
  localparam int unsigned RxSparse     = 1;
  localparam int unsigned RxEveryThird = 2;
  localparam int unsigned RxCoin       = 3;

  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainLimit = 5000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                start_req = 1'b0;
  logic                bus_level = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                pull_low;
  logic                busy_res;
  logic                reading_valid;
  logic [15:0]         raw_reading;
  logic [7:0]          temperature;
  logic [3:0]          tens_digit;
  logic [3:0]          ones_digit;

  int unsigned err_total;
  int unsigned left_over;
  logic        seq_busy;

  // one long receiver hold-off is requested from the stimulus side
  logic        hold_go = 1'b0;
  int unsigned burst_left = 0;

  always #10 clk = ~clk;

  onewire_temp_reader dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .start_req     (start_req),
    .bus_level     (bus_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pull_low      (pull_low),
    .busy_res      (busy_res),
    .reading_valid (reading_valid),
    .raw_reading   (raw_reading),
    .temperature   (temperature),
    .tens_digit    (tens_digit),
    .ones_digit    (ones_digit)
  );

  owtr_result_check reading_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .start_req     (start_req),
    .bus_level     (bus_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pull_low      (pull_low),
    .busy_res      (busy_res),
    .reading_valid (reading_valid),
    .raw_reading   (raw_reading),
    .temperature   (temperature),
    .tens_digit    (tens_digit),
    .ones_digit    (ones_digit),
    .err_total     (err_total),
    .left_over     (left_over),
    .seq_busy      (seq_busy)
  );

  // receiver side: ready follows a pattern that is picked anew at random, except for
  // one long hold-off that lets the block fill up and push back on its input
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = RxAlways;
  int unsigned hold_left = 0;
  bit          hold_taken = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HoldCycles;
      out_ready  <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(RxAlways, RxCoin);
      case (rx_mode)
        RxAlways:     out_ready <= 1'b1;
        RxSparse:     out_ready <= ($urandom_range(0, 3) != 0);
        RxEveryThird: out_ready <= (rx_cycle % 3 != 0);
        default:      out_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  function automatic logic pick_level(input int lvl);
    case (lvl)
      LvlLow:  return 1'b0;
      LvlHigh: return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // one tick beat; the sender works in bursts with random gaps in between,
  // a zero gap joins two bursts into one long unbroken stretch
  task automatic offer(input logic s, input logic b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid  <= 1'b1;
    start_req <= s;
    bus_level <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering until every predicted tick has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (left_over != 0);
  endtask

  // run out the sequence in flight with start low, then let the pipeline empty;
  // the first beat is unconditional so the busy flag seen already covers the last start
  task automatic finish_reading(input int lvl);
    do offer(1'b0, pick_level(lvl)); while (seq_busy);
    wait_drained();
    // two pipeline stages, plus a little margin before any register write
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_write <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // all six timing registers, only ever with no beat in flight
  task automatic load_timing(input int unsigned rl, input int unsigned rw, input int unsigned ws,
                             input int unsigned rc, input int unsigned rdw,
                             input int unsigned cw);
    write_reg(RegResetLow, CfgDataW'(rl));
    write_reg(RegResetWait, CfgDataW'(rw));
    write_reg(RegWriteSlot, CfgDataW'(ws));
    write_reg(RegRecovery, CfgDataW'(rc));
    write_reg(RegReadWait, CfgDataW'(rdw));
    write_reg(RegConvWait, CfgDataW'(cw));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // random ticks with a given start density; optionally a full pause halfway
  task automatic run_phase(input int unsigned n, input int unsigned start_pct, input int lvl,
                           input bit pause_mid);
    for (int unsigned i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) wait_drained();
      offer(($urandom_range(0, 99) < start_pct), pick_level(lvl));
    end
    finish_reading(lvl);
  endtask

  initial begin : stimulus
    int unsigned wait_cycles;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // timing straight out of reset: idle ticks without a start at both bus levels,
    // then a start that stays high and must be ignored while busy; the default
    // reset pulse and the first command slots run, then short timing is loaded
    // in the middle of a write slot so that slot ends at once on the new limit
    offer(1'b0, 1'b0);
    offer(1'b0, 1'b1);
    offer(1'b0, 1'b0);
    offer(1'b1, 1'b1);
    repeat (296) offer(1'b1, 1'b1);
    wait_drained();
    repeat (6) @(posedge clk);
    // bus held high so the reading is all ones, which checks the truncation
    // of the temperature and of the tens digit
    load_timing(1, 1, 1, 1, 1, 0);
    finish_reading(LvlHigh);

    // shortest timing, no conversion wait, bus held low for an all-zero reading
    load_timing(1, 1, 1, 1, 1, 0);
    repeat (3) offer(1'b1, 1'b0);
    finish_reading(LvlLow);

    // zero timing values act as one tick; the receiver holds off for a long
    // stretch here while the sender keeps going
    load_timing(0, 0, 0, 0, 0, 1);
    hold_go <= 1'b1;
    run_phase(150, 30, LvlNoise, 1'b0);

    // short mixed timing with a full drain in the middle of the phase
    load_timing(2, 3, 1, 2, 1, 7);
    run_phase(150, 50, LvlNoise, 1'b1);

    // a random short timing
    load_timing($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3),
                $urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(0, 30));
    run_phase(60, 20, LvlNoise, 1'b0);

    // largest slot timing: the reset pulse runs its full length, then short
    // timing cuts the release phase that follows
    load_timing(255, 255, 255, 255, 255, 0);
    offer(1'b1, pick_level(LvlNoise));
    repeat (259) offer(1'b0, pick_level(LvlNoise));
    wait_drained();
    repeat (6) @(posedge clk);
    load_timing(1, 1, 1, 1, 1, 0);
    finish_reading(LvlNoise);

    // largest conversion wait, cut short once the sequence sits in it
    load_timing(1, 1, 1, 1, 1, 18'h3FFFF);
    offer(1'b1, pick_level(LvlNoise));
    repeat (69) offer(1'b0, pick_level(LvlNoise));
    wait_drained();
    repeat (6) @(posedge clk);
    load_timing(1, 1, 1, 1, 1, 1);
    finish_reading(LvlNoise);

    // everything offered; give stragglers a bounded time to arrive
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (left_over != 0 && wait_cycles < DrainLimit) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (err_total == 0 && left_over == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // watchdog, well above a full run under random stalls and the long hold-off
  initial begin
    #4_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
